// ----- rtl/core/bqhp_pkg.sv -----
package bqhp_pkg;

  localparam int unsigned SAMPLE_W           = 32;
  localparam int unsigned CFG_DATA_W         = 32;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned COEF_OP_W          = 33;
  localparam int unsigned MUL_PROD_W         = 2 * COEF_OP_W;
  localparam int unsigned CHUNK_W            = 32;
  localparam int unsigned STEP_W             = 3;
  localparam int unsigned DEF_STATE_WIDTH    = 48;
  localparam int unsigned DEF_COEF_FRAC_BITS = 29;

  localparam logic [STEP_W-1:0]   LAST_STEP  = 3'd6;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7fff_ffff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RND,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYPASS    = 3'd0,
    REG_FIRST_B0  = 3'd1,
    REG_FIRST_A1  = 3'd2,
    REG_FIRST_A2  = 3'd3,
    REG_SECOND_B0 = 3'd4,
    REG_SECOND_A1 = 3'd5,
    REG_SECOND_A2 = 3'd6
  } reg_idx_e;

  typedef enum logic {
    MSRC_X,
    MSRC_Y
  } msrc_e;

  // CF_NB0X2 multiplies by -b0 and doubles the exact product, giving b1 = -2*b0
  typedef enum logic [1:0] {
    CF_B0,
    CF_NB0X2,
    CF_NA1,
    CF_NA2
  } coef_e;

  typedef enum logic [2:0] {
    OPD_ZERO,
    OPD_PROD,
    OPD_FWD,
    OPD_T,
    OPD_Y,
    OPD_D1,
    OPD_D2
  } opnd_e;

  typedef enum logic [2:0] {
    DST_FWD,
    DST_Y,
    DST_T,
    DST_D1,
    DST_D2,
    DST_X
  } dest_e;

  typedef struct packed {
    logic  mul;
    msrc_e msrc;
    coef_e coef;
    opnd_e opa;
    opnd_e opb;
    dest_e dst;
  } uop_t;

  // One step of a biquad section: optional product, then one saturating add into a register.
  function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '{mul: 1'b0, msrc: MSRC_X, coef: CF_B0, opa: OPD_ZERO, opb: OPD_ZERO, dst: DST_T};
    case (step)
      3'd0: u = '{mul: 1'b1, msrc: MSRC_X, coef: CF_B0,
                  opa: OPD_PROD, opb: OPD_ZERO, dst: DST_FWD};
      3'd1: u = '{mul: 1'b0, msrc: MSRC_X, coef: CF_B0,
                  opa: OPD_FWD, opb: OPD_D1, dst: DST_Y};
      3'd2: u = '{mul: 1'b1, msrc: MSRC_X, coef: CF_NB0X2,
                  opa: OPD_PROD, opb: OPD_ZERO, dst: DST_T};
      3'd3: u = '{mul: 1'b1, msrc: MSRC_Y, coef: CF_NA1,
                  opa: OPD_T, opb: OPD_PROD, dst: DST_T};
      3'd4: u = '{mul: 1'b0, msrc: MSRC_X, coef: CF_B0,
                  opa: OPD_T, opb: OPD_D2, dst: DST_D1};
      3'd5: u = '{mul: 1'b1, msrc: MSRC_Y, coef: CF_NA2,
                  opa: OPD_FWD, opb: OPD_PROD, dst: DST_D2};
      3'd6: u = '{mul: 1'b0, msrc: MSRC_X, coef: CF_B0,
                  opa: OPD_Y, opb: OPD_ZERO, dst: DST_X};
      default: u = '{mul: 1'b0, msrc: MSRC_X, coef: CF_B0,
                     opa: OPD_ZERO, opb: OPD_ZERO, dst: DST_T};
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/core/biquad_cascade_highpass.sv -----
// Fourth-order high-pass filter: two transposed direct form II biquads in series on
// Q1.31 samples, with Q3.29 coefficients b0, a1, a2 per section (b1 = -2*b0, b2 = b0)
// and delay registers of STATE_WIDTH bits with 31 fraction bits. Every product is
// rounded half up and every sum saturates; the result is saturated to 32 bits.
// With bypass set (the reset value) a sample comes out unchanged and the delays are
// left alone. When filtering, an item goes through eight products, each split into
// two passes through one shared 33x33 multiplier plus a rounding and an add step,
// and six add-only steps, all run by a small sequencer; the next item is accepted
// only once this result is in the output register. A waiting result does not
// block the next request. Any coefficient write clears all four delays; configure
// only while the block is idle.
module biquad_cascade_highpass
  import bqhp_pkg::*;
#(
  parameter int unsigned STATE_WIDTH    = DEF_STATE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                  block_end_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                  block_end_out_o
);

  localparam int unsigned SW   = STATE_WIDTH;
  localparam int unsigned HI_W = STATE_WIDTH - CHUNK_W;
  localparam int unsigned PW   = STATE_WIDTH + 34;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic [SW-1:0] ST_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] ST_MIN = {1'b1, {(SW-1){1'b0}}};

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              sect_q, sect_d;
  uop_t              uop;

  logic                        bypass_q;
  logic signed [COEF_OP_W-1:0] b0_q  [2];
  logic signed [COEF_OP_W-1:0] nb0_q [2];
  logic signed [COEF_OP_W-1:0] na1_q [2];
  logic signed [COEF_OP_W-1:0] na2_q [2];
  logic signed [COEF_OP_W-1:0] cfg_ext, cfg_neg;
  logic                        coef_wr;

  logic signed [SW-1:0] d1_q [2];
  logic signed [SW-1:0] d2_q [2];
  logic signed [SW-1:0] x_q, y_q, fwd_q, t_q, prod_q;
  logic                 be_q;

  logic signed [SW-1:0]         mul_src;
  logic signed [COEF_OP_W-1:0]  mul_a, coef_op;
  logic signed [MUL_PROD_W-1:0] mul_p, plo_q, phi_q;

  logic signed [PW-1:0] full, full_x, rsum, rq;
  logic signed [SW-1:0] rnd_val;

  logic signed [SW-1:0] add_a, add_b, sum_sat;
  logic signed [SW:0]   sum;

  logic                       in_acc, out_load;
  logic                       out_valid_q, out_be_q;
  logic signed [SAMPLE_W-1:0] out_sample_q, sat32;

  assign uop        = uop_at(step_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // ---------------- configuration ----------------
  assign cfg_ext = {cfg_wdata_i[CFG_DATA_W-1], cfg_wdata_i};
  assign cfg_neg = COEF_OP_W'(0) - cfg_ext;
  assign coef_wr = cfg_we_i && (cfg_index_i == REG_FIRST_B0 || cfg_index_i == REG_FIRST_A1 ||
                                cfg_index_i == REG_FIRST_A2 || cfg_index_i == REG_SECOND_B0 ||
                                cfg_index_i == REG_SECOND_A1 || cfg_index_i == REG_SECOND_A2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b1;
      for (int i = 0; i < 2; i++) begin
        b0_q[i]  <= '0;
        nb0_q[i] <= '0;
        na1_q[i] <= '0;
        na2_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BYPASS: bypass_q <= cfg_wdata_i[0];
        REG_FIRST_B0: begin
          b0_q[0]  <= cfg_ext;
          nb0_q[0] <= cfg_neg;
        end
        REG_FIRST_A1:  na1_q[0] <= cfg_neg;
        REG_FIRST_A2:  na2_q[0] <= cfg_neg;
        REG_SECOND_B0: begin
          b0_q[1]  <= cfg_ext;
          nb0_q[1] <= cfg_neg;
        end
        REG_SECOND_A1: na1_q[1] <= cfg_neg;
        REG_SECOND_A2: na2_q[1] <= cfg_neg;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      sect_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sect_q  <= sect_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    sect_d  = sect_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          step_d  = '0;
          sect_d  = 1'b0;
          state_d = bypass_q ? ST_OUT : (uop_at('0).mul ? ST_MUL_LO : ST_ADD);
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_RND;
      ST_RND:    state_d = ST_ADD;
      ST_ADD: begin
        if (step_q == LAST_STEP) begin
          if (sect_q) begin
            state_d = ST_OUT;
          end else begin
            sect_d  = 1'b1;
            step_d  = '0;
            state_d = uop_at('0).mul ? ST_MUL_LO : ST_ADD;
          end
        end else begin
          step_d  = step_q + STEP_W'(1);
          state_d = uop_at(step_q + STEP_W'(1)).mul ? ST_MUL_LO : ST_ADD;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- shared multiplier ----------------
  assign mul_src = (uop.msrc == MSRC_X) ? x_q : y_q;

  // low chunk is unsigned, high chunk carries the sign
  assign mul_a = (state_q == ST_MUL_HI) ?
                 {{(COEF_OP_W-HI_W){mul_src[SW-1]}}, mul_src[SW-1:CHUNK_W]} :
                 {1'b0, mul_src[CHUNK_W-1:0]};

  always_comb begin
    case (uop.coef)
      CF_B0:    coef_op = b0_q[sect_q];
      CF_NB0X2: coef_op = nb0_q[sect_q];
      CF_NA1:   coef_op = na1_q[sect_q];
      CF_NA2:   coef_op = na2_q[sect_q];
      default:  coef_op = '0;
    endcase
  end

  assign mul_p = mul_a * coef_op;

  // combine partial products, round half up, saturate to the state width
  assign full   = (PW'(phi_q) <<< CHUNK_W) + PW'(plo_q);
  assign full_x = (uop.coef == CF_NB0X2) ? (full <<< 1) : full;
  assign rsum   = full_x + RND_HALF;
  assign rq     = rsum >>> COEF_FRAC_BITS;

  always_comb begin
    if ((&rq[PW-1:SW-1]) || !(|rq[PW-1:SW-1])) begin
      rnd_val = rq[SW-1:0];
    end else begin
      rnd_val = rq[PW-1] ? ST_MIN : ST_MAX;
    end
  end

  // ---------------- shared saturating adder ----------------
  always_comb begin
    case (uop.opa)
      OPD_PROD: add_a = prod_q;
      OPD_FWD:  add_a = fwd_q;
      OPD_T:    add_a = t_q;
      OPD_Y:    add_a = y_q;
      OPD_D1:   add_a = d1_q[sect_q];
      OPD_D2:   add_a = d2_q[sect_q];
      default:  add_a = '0;
    endcase
    case (uop.opb)
      OPD_PROD: add_b = prod_q;
      OPD_FWD:  add_b = fwd_q;
      OPD_T:    add_b = t_q;
      OPD_Y:    add_b = y_q;
      OPD_D1:   add_b = d1_q[sect_q];
      OPD_D2:   add_b = d2_q[sect_q];
      default:  add_b = '0;
    endcase
  end

  assign sum     = {add_a[SW-1], add_a} + {add_b[SW-1], add_b};
  assign sum_sat = (sum[SW] != sum[SW-1]) ? (sum[SW] ? ST_MIN : ST_MAX) : sum[SW-1:0];

  // ---------------- working registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q  <= {{(SW-SAMPLE_W){sample_in_i[SAMPLE_W-1]}}, sample_in_i};
      be_q <= block_end_in_i;
    end
    case (state_q)
      ST_MUL_LO: plo_q  <= mul_p;
      ST_MUL_HI: phi_q  <= mul_p;
      ST_RND:    prod_q <= rnd_val;
      ST_ADD: begin
        case (uop.dst)
          DST_FWD: fwd_q <= sum_sat;
          DST_Y:   y_q   <= sum_sat;
          DST_T:   t_q   <= sum_sat;
          DST_X:   x_q   <= sum_sat;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (coef_wr) begin
      for (int i = 0; i < 2; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (state_q == ST_ADD) begin
      if (uop.dst == DST_D1) begin
        d1_q[sect_q] <= sum_sat;
      end
      if (uop.dst == DST_D2) begin
        d2_q[sect_q] <= sum_sat;
      end
    end
  end

  // ---------------- result register ----------------
  assign sat32 = ((&x_q[SW-1:SAMPLE_W-1]) || !(|x_q[SW-1:SAMPLE_W-1])) ?
                 x_q[SAMPLE_W-1:0] : (x_q[SW-1] ? SAMPLE_MIN : SAMPLE_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= sat32;
      out_be_q     <= be_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_sample_q;
  assign block_end_out_o = out_be_q;

  // ---------------- assertions ----------------
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && out_stall_i) |=> (state_q == ST_OUT && out_valid_q))
    else $error("result dropped while output register was full");

  a_bypass_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && bypass_q) |=> (state_q == ST_OUT))
    else $error("bypass request did not go straight to output");

  a_coef_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_wr |=> (d1_q[0] == '0 && d2_q[0] == '0 && d1_q[1] == '0 && d2_q[1] == '0))
    else $error("delays not cleared after coefficient write");

endmodule

// ----- tb/biquad_cascade_highpass_tb.sv -----
module biquad_cascade_highpass_tb;
  import bqhp_pkg::*;

  localparam int unsigned STATE_W  = DEF_STATE_WIDTH;
  localparam int unsigned FRAC_W   = DEF_COEF_FRAC_BITS;
  localparam longint STATE_MAX     = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
  localparam longint STATE_MIN     = -STATE_MAX - 64'sd1;
  localparam longint PCM_MAX       = 64'sd2147483647;
  localparam longint PCM_MIN       = -64'sd2147483648;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 4;
  localparam int END_WAIT     = 50;

  // Butterworth fourth-order high-pass, two cutoffs, Q3.29
  localparam int HP_A_B0_1 = 407415229;
  localparam int HP_A_A1_1 = -794386414;
  localparam int HP_A_A2_1 = 298398232;
  localparam int HP_A_B0_2 = 468344708;
  localparam int HP_A_A1_2 = -913190577;
  localparam int HP_A_A2_2 = 423317345;
  localparam int HP_B_B0_1 = 506932843;
  localparam int HP_B_A1_1 = -1012864987;
  localparam int HP_B_A2_1 = 477996568;
  localparam int HP_B_B0_2 = 523755692;
  localparam int HP_B_A1_2 = -1046476834;
  localparam int HP_B_A2_2 = 511675560;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pcm;
    logic                block_end;
  } hp_result_t;

  class highpass_cascade;
    bit         bypass;
    longint     b0[2], a1[2], a2[2];
    longint     d1[2], d2[2];
    hp_result_t pending_outputs[$];
    int         errors, filtered, passed;

    function new();
      bypass = 1'b1;
      foreach (b0[k]) begin
        b0[k] = 0;
        a1[k] = 0;
        a2[k] = 0;
      end
      clear_delays();
      errors   = 0;
      filtered = 0;
      passed   = 0;
    endfunction

    function void clear_delays();
      foreach (d1[k]) begin
        d1[k] = 0;
        d2[k] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      longint c;
      c = $signed(val);
      case (idx)
        REG_BYPASS:    bypass = val[0];
        REG_FIRST_B0:  begin b0[0] = c; clear_delays(); end
        REG_FIRST_A1:  begin a1[0] = c; clear_delays(); end
        REG_FIRST_A2:  begin a2[0] = c; clear_delays(); end
        REG_SECOND_B0: begin b0[1] = c; clear_delays(); end
        REG_SECOND_A1: begin a1[1] = c; clear_delays(); end
        REG_SECOND_A2: begin a2[1] = c; clear_delays(); end
        default: ;
      endcase
    endfunction

    function longint limit_state(logic signed [95:0] v);
      if (v > STATE_MAX) return STATE_MAX;
      if (v < STATE_MIN) return STATE_MIN;
      return v[63:0];
    endfunction

    // exact product, round half up, drop the coefficient fraction bits
    function longint scaled_product(longint x, longint c);
      logic signed [95:0] px, pc, p;
      px = x;
      pc = c;
      p  = px * pc;
      p  = p + (96'sd1 <<< (FRAC_W - 1));
      return limit_state(p >>> FRAC_W);
    endfunction

    function longint sat_sum(longint a, longint b);
      logic signed [95:0] s;
      s = a;
      s = s + b;
      return limit_state(s);
    endfunction

    function longint run_section(int k, longint x);
      longint fwd, y, t;
      fwd   = scaled_product(x, b0[k]);
      y     = sat_sum(fwd, d1[k]);
      t     = sat_sum(scaled_product(x, -2 * b0[k]), scaled_product(y, -a1[k]));
      d1[k] = sat_sum(t, d2[k]);
      d2[k] = sat_sum(fwd, scaled_product(y, -a2[k]));
      return y;
    endfunction

    function void note_input(logic [SAMPLE_W-1:0] s, logic be);
      hp_result_t r;
      longint     y;
      r.block_end = be;
      if (bypass) begin
        r.pcm = s;
        passed++;
      end else begin
        y = run_section(0, $signed(s));
        y = run_section(1, y);
        if (y > PCM_MAX) y = PCM_MAX;
        else if (y < PCM_MIN) y = PCM_MIN;
        r.pcm = y[SAMPLE_W-1:0];
        filtered++;
      end
      pending_outputs.push_back(r);
    endfunction

    function void check_output(logic [SAMPLE_W-1:0] s, logic be);
      hp_result_t e;
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: expected none, actual %h / %b", $time, s, be);
        return;
      end
      e = pending_outputs.pop_front();
      if (s !== e.pcm) begin
        errors++;
        $display("%0t: sample_out mismatch: expected %h, actual %h", $time, e.pcm, s);
      end
      if (be !== e.block_end) begin
        errors++;
        $display("%0t: block_end_out mismatch: expected %b, actual %b",
                 $time, e.block_end, be);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic                  block_end_in_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                  block_end_out_o;

  highpass_cascade filter_model;
  bit              idle_en;
  int              hold_reqs = 0;
  int              holds_done = 0;
  int              quiet_cycles = 0;
  int              coef_loads;

  biquad_cascade_highpass dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_in_i    (sample_in_i),
    .block_end_in_i (block_end_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o),
    .block_end_out_o(block_end_out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        filter_model.note_input(sample_in_i, block_end_in_i);
      if (out_valid_o && !out_stall_i)
        filter_model.check_output(sample_out_o, block_end_out_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: random stall bursts, or one long hold on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: v = SAMPLE_MAX;
          1: v = SAMPLE_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1: v = $signed(v) >>> $urandom_range(8, 28);
      2: v = $urandom_range(0, 131071) - 65536;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic be);
    in_valid_i     <= 1'b1;
    sample_in_i    <= s;
    block_end_in_i <= be;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic feed(input int n);
    repeat (n) begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      send_sample(random_sample(), $urandom_range(0, 7) == 0);
    end
  endtask

  // hold off the input until every output has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (filter_model.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    filter_model.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // upper data bits are don't-care for bypass; keep them random
  task automatic set_bypass(input bit on);
    logic [CFG_DATA_W-1:0] v;
    v    = $urandom;
    v[0] = on;
    write_reg(REG_BYPASS, v);
  endtask

  task automatic load_coefs(input int fb0, input int fa1, input int fa2,
                            input int sb0, input int sa1, input int sa2);
    write_reg(REG_FIRST_B0, fb0);
    write_reg(REG_FIRST_A1, fa1);
    write_reg(REG_FIRST_A2, fa2);
    write_reg(REG_SECOND_B0, sb0);
    write_reg(REG_SECOND_A1, sa1);
    write_reg(REG_SECOND_A2, sa2);
    coef_loads++;
  endtask

  initial begin
    filter_model    = new();
    idle_en         = 1'b1;
    coef_loads      = 0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= REG_BYPASS;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    sample_in_i    <= '0;
    block_end_in_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bypass out of reset
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b1);
    send_sample('1, 1'b0);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'haaaa_aaaa, 1'b1);
    drain();

    load_coefs(HP_A_B0_1, HP_A_A1_1, HP_A_A2_1, HP_A_B0_2, HP_A_A1_2, HP_A_A2_2);
    set_bypass(1'b0);
    // impulse, step, then full-scale Nyquist tone to push the output into saturation
    send_sample(SAMPLE_MAX, 1'b0);
    repeat (3) send_sample('0, 1'b0);
    repeat (3) send_sample(SAMPLE_MIN, 1'b0);
    repeat (2) begin
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
    end
    send_sample(32'sd1, 1'b0);
    send_sample(-32'sd1, 1'b1);
    send_sample('0, 1'b0);

    // long output hold while the input keeps coming
    hold_reqs++;
    feed(450);
    drain();

    // bypass must leave the delays alone
    set_bypass(1'b1);
    feed(100);
    drain();
    set_bypass(1'b0);
    feed(100);
    drain();

    write_reg(REG_UNMAPPED, $urandom);
    feed(100);
    drain();

    // rewriting a coefficient with its own value still clears the delays
    write_reg(REG_FIRST_A1, HP_A_A1_1);
    feed(100);
    drain();

    load_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    feed(120);
    drain();
    load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    feed(120);
    drain();
    load_coefs(0, 0, 0, 0, 0, 0);
    feed(50);
    drain();

    repeat (4) begin
      load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      feed(50);
      drain();
    end

    load_coefs(HP_B_B0_1, HP_B_A1_1, HP_B_A2_1, HP_B_B0_2, HP_B_A1_2, HP_B_A2_2);
    feed(150);
    drain();

    idle_en = 1'b0;
    load_coefs(HP_A_B0_1, HP_A_A1_1, HP_A_A2_1, HP_A_B0_2, HP_A_A1_2, HP_A_A2_2);
    feed(350);
    drain();
    repeat (END_WAIT) @(posedge clk_i);

    $display("Ran %0d filtered and %0d bypassed samples over %0d coefficient loads,",
             filter_model.filtered, filter_model.passed, coef_loads);
    $display("with a long output hold, drained pauses, coefficient extremes and no idling.");
    if (filter_model.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", filter_model.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
